// ===== design/sgrel_pkg.sv =====
// types and constants shared by the sgr echo line recognizer
`timescale 1ns / 1ps
package sgrel_pkg;

  // parse phase, one-hot
  typedef enum logic [7:0] {
    PH_OPEN_ESC     = 8'b0000_0001,
    PH_OPEN_LB      = 8'b0000_0010,
    PH_OPEN_PARAMS  = 8'b0000_0100,
    PH_CONTENT      = 8'b0000_1000,
    PH_CLOSE_LB     = 8'b0001_0000,
    PH_CLOSE_PARAMS = 8'b0010_0000,
    PH_TRAILING     = 8'b0100_0000,
    PH_FAILED       = 8'b1000_0000
  } phase_e;

  typedef logic [3:0] prefix_t;

  typedef struct packed {
    phase_e  phase;
    prefix_t prefix;
  } parse_state_t;

  localparam logic [7:0] EscByte = 8'h1b;

  // opening parameter prefix codes
  localparam prefix_t PfxEmpty    = 4'd0;
  localparam prefix_t Pfx3        = 4'd1;
  localparam prefix_t Pfx36       = 4'd2;
  localparam prefix_t Pfx36Semi   = 4'd3;
  localparam prefix_t Pfx36Semi1  = 4'd4;
  localparam prefix_t Pfx1        = 4'd5;
  localparam prefix_t Pfx1Semi    = 4'd6;
  localparam prefix_t Pfx1Semi3   = 4'd7;
  localparam prefix_t Pfx1Semi36  = 4'd8;

  // closing parameter prefix codes
  localparam prefix_t PfxClose0   = 4'd1;
  localparam prefix_t PfxClose3   = 4'd2;
  localparam prefix_t PfxClose39  = 4'd3;

  localparam prefix_t PrefixDead  = 4'd15;

  localparam parse_state_t ParseReset = '{phase: PH_OPEN_ESC, prefix: PfxEmpty};

endpackage

// ===== design/sgrel_step.sv =====
// next parse state for one byte of a line
`timescale 1ns / 1ps
module sgrel_step import sgrel_pkg::*; (
  input  parse_state_t cur_i,
  input  logic         byte_present_i,
  input  logic [7:0]   text_byte_i,
  output parse_state_t nxt_o
);

  function automatic prefix_t open_next(input prefix_t p, input logic [7:0] c);
    prefix_t r;
    r = PrefixDead;
    case (p)
      PfxEmpty:  r = (c == "3") ? Pfx3 : ((c == "1") ? Pfx1 : PrefixDead);
      Pfx3:      r = (c == "6") ? Pfx36 : PrefixDead;
      Pfx36:     r = (c == ";") ? Pfx36Semi : PrefixDead;
      Pfx36Semi: r = (c == "1") ? Pfx36Semi1 : PrefixDead;
      Pfx1:      r = (c == ";") ? Pfx1Semi : PrefixDead;
      Pfx1Semi:  r = (c == "3") ? Pfx1Semi3 : PrefixDead;
      Pfx1Semi3: r = (c == "6") ? Pfx1Semi36 : PrefixDead;
      default:   r = PrefixDead;
    endcase
    return r;
  endfunction

  function automatic prefix_t close_next(input prefix_t p, input logic [7:0] c);
    prefix_t r;
    r = PrefixDead;
    case (p)
      PfxEmpty:  r = (c == "0") ? PfxClose0 : ((c == "3") ? PfxClose3 : PrefixDead);
      PfxClose3: r = (c == "9") ? PfxClose39 : PrefixDead;
      default:   r = PrefixDead;
    endcase
    return r;
  endfunction

  logic    is_param;
  logic    ws_byte;
  prefix_t open_n;
  prefix_t close_n;

  assign is_param = (text_byte_i inside {["0":"9"], ";"});
  assign ws_byte  = (text_byte_i inside {" ", 8'h09, 8'h0d, 8'h0a});
  assign open_n   = open_next(cur_i.prefix, text_byte_i);
  assign close_n  = close_next(cur_i.prefix, text_byte_i);

  always_comb begin
    nxt_o = cur_i;
    if (byte_present_i) begin
      case (cur_i.phase)
        PH_OPEN_ESC: begin
          nxt_o.phase = (text_byte_i == EscByte) ? PH_OPEN_LB : PH_FAILED;
        end
        PH_OPEN_LB: begin
          if (text_byte_i == "[") begin
            nxt_o.phase  = PH_OPEN_PARAMS;
            nxt_o.prefix = PfxEmpty;
          end else begin
            nxt_o.phase = PH_FAILED;
          end
        end
        PH_OPEN_PARAMS: begin
          if (text_byte_i == "m") begin
            nxt_o.phase  = (cur_i.prefix inside {Pfx36Semi1, Pfx1Semi36}) ? PH_CONTENT
                                                                           : PH_FAILED;
            nxt_o.prefix = PfxEmpty;
          end else if (is_param) begin
            if (open_n == PrefixDead) nxt_o.phase = PH_FAILED;
            else nxt_o.prefix = open_n;
          end else begin
            nxt_o.phase = PH_FAILED;
          end
        end
        PH_CONTENT: begin
          if (text_byte_i == EscByte) nxt_o.phase = PH_CLOSE_LB;
        end
        PH_CLOSE_LB: begin
          if (text_byte_i == "[") begin
            nxt_o.phase  = PH_CLOSE_PARAMS;
            nxt_o.prefix = PfxEmpty;
          end else begin
            nxt_o.phase = PH_FAILED;
          end
        end
        PH_CLOSE_PARAMS: begin
          if (text_byte_i == "m") begin
            nxt_o.phase  = (cur_i.prefix inside {PfxEmpty, PfxClose0, PfxClose39})
                           ? PH_TRAILING : PH_FAILED;
            nxt_o.prefix = PfxEmpty;
          end else if (is_param) begin
            if (close_n == PrefixDead) nxt_o.phase = PH_FAILED;
            else nxt_o.prefix = close_n;
          end else begin
            nxt_o.phase = PH_FAILED;
          end
        end
        PH_TRAILING: begin
          if (!ws_byte) nxt_o.phase = PH_FAILED;
        end
        default: begin
          nxt_o.phase = PH_FAILED;
        end
      endcase
    end
  end

endmodule

// ===== design/sgr_echo_line_recognizer_core.sv =====
// top level of the sgr echo line recognizer
`timescale 1ns / 1ps
// path: each item passes through the input register and the parse step; a line's verdict
//   is then held in the result register until it is taken
// throughput: one item per cycle, set by the single phase/prefix update per cycle;
//   a line end waits only while the previous verdict is still untaken
// reset: rst_ni clears both registers' valid flags and the parse state to
//   "expect opening escape" with an empty parameter prefix
module sgr_echo_line_recognizer_core import sgrel_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       byte_present_i,
  input  logic [7:0] text_byte_i,
  input  logic       end_of_line_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       line_matches_o
);

  // input register
  logic         in_valid_q;
  logic         present_q;
  logic [7:0]   byte_q;
  logic         eol_q;

  // parse state of the current line
  parse_state_t state_q, state_d;
  parse_state_t step_nxt;

  // result register
  logic         out_valid_q, out_valid_d;
  logic         match_q, match_d;

  logic         advance;

  // an item leaves the input register unless it ends a line and the
  // result register is still holding an untaken verdict
  assign advance    = in_valid_q & (~eol_q | ~out_valid_q | out_ready_i);
  assign in_ready_o = ~in_valid_q | advance;

  sgrel_step u_step (
    .cur_i          (state_q),
    .byte_present_i (present_q),
    .text_byte_i    (byte_q),
    .nxt_o          (step_nxt)
  );

  // the state returns to reset at every line end
  always_comb begin
    state_d = state_q;
    if (advance) begin
      state_d = eol_q ? ParseReset : step_nxt;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q & ~out_ready_i;
    match_d     = match_q;
    if (advance && eol_q) begin
      out_valid_d = 1'b1;
      match_d     = (step_nxt.phase == PH_TRAILING);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      state_q     <= ParseReset;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) in_valid_q <= in_valid_i;
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      present_q <= byte_present_i;
      byte_q    <= text_byte_i;
      eol_q     <= end_of_line_i;
    end
    match_q <= match_d;
  end

  assign out_valid_o    = out_valid_q;
  assign line_matches_o = match_q;

endmodule

// ===== tb/tb_sgr_echo_line_recognizer_core.sv =====
// self-checking testbench for the sgr echo line recognizer core
`timescale 1ns / 1ps
module tb_sgr_echo_line_recognizer_core;
  import sgrel_pkg::*;

  // watchdog: cycles in a row with no item moving on either channel
  localparam int unsigned IdleLimit   = 2000;
  localparam int unsigned RandomItems = 1400;

  localparam logic [7:0] ChLbr   = "[";
  localparam logic [7:0] ChM     = "m";
  localparam logic [7:0] ChSemi  = ";";
  localparam logic [7:0] ChSpace = " ";
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChLf    = 8'h0a;
  localparam logic [7:0] ChCr    = 8'h0d;

  typedef struct {
    logic       present;
    logic [7:0] data;
    logic       eol;
    bit         hold;   // sender waits for all verdicts before this item
  } text_item_t;

  // parameter texts, accepted and near misses
  string open_ok[2]   = '{"36;1", "1;36"};
  string open_bad[8]  = '{"36;", "3", "1;3", "36;11", "136", "", "1;6", "6;1"};
  string close_ok[3]  = '{"", "0", "39"};
  string close_bad[6] = '{"00", "9", "3", "390", "1", "39;"};
  string spice        = "0369;m[";

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       byte_present = 1'b0;
  logic [7:0] text_byte = 8'h00;
  logic       end_of_line = 1'b0;
  logic       out_ready = 1'b0;
  logic       in_ready;
  logic       out_valid;
  logic       line_matches;

  text_item_t   pending_items[$];
  logic [7:0]   line_buf[$];
  logic         verdict_q[$];
  parse_state_t scan_st = ParseReset;
  text_item_t   head_item;
  bit           hold_next;
  logic         want_match;

  int gap_left = 0;
  int burst_left = 0;
  int rx_cycle = 0;
  int rx_mode = 0;
  int idle_cycles = 0;
  int items_sent = 0;
  int lines_checked = 0;
  int lines_matched = 0;
  int err_cnt = 0;

  sgr_echo_line_recognizer_core uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .byte_present_i (byte_present),
    .text_byte_i    (text_byte),
    .end_of_line_i  (end_of_line),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .line_matches_o (line_matches)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // line parser: advances the expected parse state by one byte
  // --------------------------------------------------------------------------
  task automatic scan_byte(input logic [7:0] c);
    prefix_t nxt;
    nxt = PrefixDead;
    case (scan_st.phase)
      PH_OPEN_ESC: begin
        scan_st.phase = (c == EscByte) ? PH_OPEN_LB : PH_FAILED;
      end
      PH_OPEN_LB: begin
        if (c == ChLbr) begin
          scan_st.phase  = PH_OPEN_PARAMS;
          scan_st.prefix = PfxEmpty;
        end else begin
          scan_st.phase = PH_FAILED;
        end
      end
      PH_OPEN_PARAMS: begin
        if (c == ChM) begin
          // only the two full color/bold texts open a span
          scan_st.phase = (scan_st.prefix == Pfx36Semi1 || scan_st.prefix == Pfx1Semi36) ?
                          PH_CONTENT : PH_FAILED;
          scan_st.prefix = PfxEmpty;
        end else begin
          // anything off the "36;1" / "1;36" paths kills the line
          case (scan_st.prefix)
            PfxEmpty: begin
              if (c == "3") nxt = Pfx3;
              else if (c == "1") nxt = Pfx1;
            end
            Pfx3:      if (c == "6") nxt = Pfx36;
            Pfx36:     if (c == ChSemi) nxt = Pfx36Semi;
            Pfx36Semi: if (c == "1") nxt = Pfx36Semi1;
            Pfx1:      if (c == ChSemi) nxt = Pfx1Semi;
            Pfx1Semi:  if (c == "3") nxt = Pfx1Semi3;
            Pfx1Semi3: if (c == "6") nxt = Pfx1Semi36;
            default:   nxt = PrefixDead;
          endcase
          if (nxt == PrefixDead) scan_st.phase = PH_FAILED;
          else scan_st.prefix = nxt;
        end
      end
      PH_CONTENT: begin
        // content is free text up to the next escape
        if (c == EscByte) scan_st.phase = PH_CLOSE_LB;
      end
      PH_CLOSE_LB: begin
        if (c == ChLbr) begin
          scan_st.phase  = PH_CLOSE_PARAMS;
          scan_st.prefix = PfxEmpty;
        end else begin
          scan_st.phase = PH_FAILED;
        end
      end
      PH_CLOSE_PARAMS: begin
        if (c == ChM) begin
          // reset forms: empty, "0" or "39"
          scan_st.phase = (scan_st.prefix == PfxEmpty || scan_st.prefix == PfxClose0 ||
                           scan_st.prefix == PfxClose39) ? PH_TRAILING : PH_FAILED;
          scan_st.prefix = PfxEmpty;
        end else begin
          case (scan_st.prefix)
            PfxEmpty: begin
              if (c == "0") nxt = PfxClose0;
              else if (c == "3") nxt = PfxClose3;
            end
            PfxClose3: if (c == "9") nxt = PfxClose39;
            default:   nxt = PrefixDead;
          endcase
          if (nxt == PrefixDead) scan_st.phase = PH_FAILED;
          else scan_st.prefix = nxt;
        end
      end
      PH_TRAILING: begin
        if (!(c == ChSpace || c == ChTab || c == ChCr || c == ChLf))
          scan_st.phase = PH_FAILED;
      end
      default: scan_st.phase = PH_FAILED;
    endcase
  endtask

  // --------------------------------------------------------------------------
  // stimulus building
  // --------------------------------------------------------------------------
  task automatic add_item(input logic p, input logic [7:0] d, input logic e);
    pending_items.push_back('{present: p, data: d, eol: e, hold: hold_next});
    hold_next = 1'b0;
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endtask

  // turns line_buf into items: stray byteless items inside the line, and
  // sometimes a byteless item carries the line end
  task automatic emit_line();
    bit tail;
    tail = (line_buf.size() == 0) || ($urandom_range(0, 5) == 0);
    foreach (line_buf[i]) begin
      if ($urandom_range(0, 15) == 0) add_item(1'b0, 8'($urandom_range(0, 255)), 1'b0);
      add_item(1'b1, line_buf[i], (i == line_buf.size() - 1) && !tail);
    end
    if (tail) add_item(1'b0, 8'($urandom_range(0, 255)), 1'b1);
    line_buf.delete();
  endtask

  // mostly well-formed spans with random content, some damaged, some noise
  task automatic build_random_line();
    int n;
    int pos;
    logic [7:0] b;
    line_buf.delete();
    if ($urandom_range(0, 9) < 8) begin
      line_buf.push_back(EscByte);
      line_buf.push_back(ChLbr);
      if ($urandom_range(0, 4) != 0) add_text(open_ok[$urandom_range(0, 1)]);
      else add_text(open_bad[$urandom_range(0, 7)]);
      line_buf.push_back(ChM);
      n = $urandom_range(0, 10);
      repeat (n) begin
        b = 8'($urandom_range(0, 255));
        if (b == EscByte) b = "E";
        line_buf.push_back(b);
      end
      line_buf.push_back(EscByte);
      line_buf.push_back(ChLbr);
      if ($urandom_range(0, 4) != 0) add_text(close_ok[$urandom_range(0, 2)]);
      else add_text(close_bad[$urandom_range(0, 5)]);
      line_buf.push_back(ChM);
      n = $urandom_range(0, 3);
      repeat (n) begin
        case ($urandom_range(0, 3))
          0: line_buf.push_back(ChSpace);
          1: line_buf.push_back(ChTab);
          2: line_buf.push_back(ChCr);
          default: line_buf.push_back(ChLf);
        endcase
      end
      // damage a share of the spans
      if ($urandom_range(0, 9) < 3) begin
        pos = $urandom_range(0, line_buf.size() - 1);
        case ($urandom_range(0, 3))
          0: begin
            if ($urandom_range(0, 1) == 0) b = 8'($urandom_range(0, 255));
            else if ($urandom_range(0, 3) == 0) b = EscByte;
            else b = spice[$urandom_range(0, spice.len() - 1)];
            line_buf[pos] = b;
          end
          1: while (line_buf.size() > pos) void'(line_buf.pop_back());
          2: line_buf.insert(pos, 8'($urandom_range(0, 255)));
          default: line_buf.push_back(8'($urandom_range(33, 126)));
        endcase
      end
    end else begin
      n = $urandom_range(0, 8);
      if (n > 0 && $urandom_range(0, 1) == 0) line_buf.push_back(EscByte);
      repeat (n) line_buf.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  // --------------------------------------------------------------------------
  // driver: bursts with gaps, predicts each accepted item
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        items_sent++;
        if (byte_present) scan_byte(text_byte);
        if (end_of_line) begin
          verdict_q.push_back(scan_st.phase == PH_TRAILING);
          scan_st = ParseReset;
        end
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_items.size() == 0 ||
                     (pending_items[0].hold && verdict_q.size() != 0)) begin
          // out of items, or draining all verdicts before a held item
          in_valid <= 1'b0;
        end else begin
          head_item = pending_items.pop_front();
          in_valid     <= 1'b1;
          byte_present <= head_item.present;
          text_byte    <= head_item.data;
          end_of_line  <= head_item.eol;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
  end

  // receiver: stall style picked at random among four modes
  always @(posedge clk) begin
    rx_cycle++;
    if (rx_cycle % 256 == 0) rx_mode = $urandom_range(0, 3);
    case (rx_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 9) < 7);
      2: out_ready <= ((rx_cycle % 8) < 5);
      default: out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // monitor: each verdict against the oldest expected one
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (verdict_q.size() == 0) begin
        $error("line_matches: unexpected result %0b with no line pending", line_matches);
        err_cnt++;
      end else begin
        want_match = verdict_q.pop_front();
        lines_checked++;
        if (want_match) lines_matched++;
        if (line_matches !== want_match) begin
          $error("line_matches: expected %0b, got %0b", want_match, line_matches);
          err_cnt++;
        end
      end
    end
  end

  // watchdog on handshake progress
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("timeout after %0d cycles without progress", idle_cycles);
        $display("sgr_echo_line_recognizer_core regression: fail");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // test sequence
  // --------------------------------------------------------------------------
  initial begin
    int directed_cnt;

    // empty line
    emit_line();
    // byteless item inside a line, then a full span: byte extremes in the
    // content, "1;36" open, "39" close, whitespace tail
    add_item(1'b0, 8'hff, 1'b0);
    line_buf = {EscByte, ChLbr, "1", ChSemi, "3", "6", ChM, 8'h00, 8'hff,
                EscByte, ChLbr, "3", "9", ChM, ChTab};
    emit_line();
    // escape without bracket
    line_buf = {EscByte, "x"};
    emit_line();
    // bad parameter byte, line also ends inside the parameters
    line_buf = {EscByte, ChLbr, "3", "7"};
    emit_line();
    directed_cnt = pending_items.size();

    // random lines; the first one waits for every verdict to drain
    hold_next = 1'b1;
    while (pending_items.size() < directed_cnt + RandomItems) begin
      build_random_line();
      if ($urandom_range(0, 29) == 0) hold_next = 1'b1;
      emit_line();
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_items.size() != 0 || in_valid || verdict_q.size() != 0) @(posedge clk);
    // let any stray verdict show up
    repeat (8) @(posedge clk);

    $display("covered %0d items over %0d lines, %0d recognized as echo spans",
             items_sent, lines_checked, lines_matched);
    if (err_cnt == 0) begin
      $display("sgr_echo_line_recognizer_core regression: pass");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("sgr_echo_line_recognizer_core regression: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/sgrel_pkg.sv
design/sgrel_step.sv
design/sgr_echo_line_recognizer_core.sv
tb/tb_sgr_echo_line_recognizer_core.sv
